// ----- src/assert_macros.svh -----
// Assertion helpers for the checker file.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/scfc_pkg.sv -----
package scfc_pkg;

   localparam int FRAME_BYTES_DEF = 64;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_A    = 8'h41;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_L    = 8'h4C;
   localparam logic [7:0] CH_R    = 8'h52;

   typedef enum logic [1:0] {
      ST_STORED  = 2'd0,
      ST_VALID   = 2'd1,
      ST_INVALID = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic is_cmd_letter(input logic [7:0] b);
      return (b == CH_A) || (b == CH_P) || (b == CH_L) || (b == CH_R);
   endfunction

endpackage

// ----- src/scfc_frame.sv -----
module scfc_frame
   import scfc_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output status_type status
);

   localparam int CountW = $clog2(FRAME_BYTES + 1);

   logic [CountW-1:0] count_ff, count_in;
   logic              hash_ff, hash_in;
   logic              letter_ff, letter_in;
   logic              zero_ff, zero_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        recent_ff [3];

   logic              is_full;
   logic              is_bang;
   logic              is_hash;
   logic              shift_en;
   logic [7:0]        hi, mid, lo;
   logic [8:0]        value;
   logic [7:0]        body_sum;
   logic              digits_ok;
   logic              frame_ok;

   assign is_full = count_ff >= CountW'(FRAME_BYTES);
   assign is_bang = rx_byte == CH_BANG;
   assign is_hash = rx_byte == CH_HASH;

   // first digit is the oldest byte of the window
   assign hi  = recent_ff[2];
   assign mid = recent_ff[1];
   assign lo  = recent_ff[0];

   assign value = 9'(hi[3:0]) * 9'd100 + 9'(mid[3:0]) * 9'd10 + 9'(lo[3:0]);
   assign body_sum = sum_ff - hi - mid - lo;

   assign digits_ok = is_digit(hi) && is_digit(mid) && is_digit(lo)
                      && (hi <= CH_ZERO + 8'd2)
                      && !((hi == CH_ZERO + 8'd2) && (mid > CH_ZERO + 8'd5));

   assign frame_ok = (count_ff >= CountW'(5)) && hash_ff && letter_ff && !zero_ff
                     && digits_ok && (value == {1'b0, body_sum});

   assign shift_en = step && !is_full && !is_bang;

   always_comb begin
      logic [CountW-1:0] pos;
      logic              h, l, z;
      logic [7:0]        s;
      pos = is_hash ? '0 : count_ff;
      h   = is_hash ? 1'b0 : hash_ff;
      l   = is_hash ? 1'b0 : letter_ff;
      z   = is_hash ? 1'b0 : zero_ff;
      s   = is_hash ? 8'd0 : sum_ff;
      count_in  = '0;
      hash_in   = 1'b0;
      letter_in = 1'b0;
      zero_in   = 1'b0;
      sum_in    = 8'd0;
      status    = ST_STORED;
      if (is_full) begin
         status = ST_FULL;
      end else if (is_bang) begin
         status = frame_ok ? ST_VALID : ST_INVALID;
      end else begin
         hash_in   = (pos == '0) ? is_hash : h;
         letter_in = (pos == CountW'(1)) ? is_cmd_letter(rx_byte) : l;
         zero_in   = z || (rx_byte == 8'd0);
         sum_in    = (pos != '0) ? s + rx_byte : s;
         count_in  = pos + CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hash_ff   <= 1'b0;
         letter_ff <= 1'b0;
         zero_ff   <= 1'b0;
         sum_ff    <= 8'd0;
      end else if (step) begin
         count_ff  <= count_in;
         hash_ff   <= hash_in;
         letter_ff <= letter_in;
         zero_ff   <= zero_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         recent_ff[2] <= recent_ff[1];
         recent_ff[1] <= recent_ff[0];
         recent_ff[0] <= rx_byte;
      end
   end

endmodule

// ----- src/serial_command_frame_checker.sv -----
// An accepted byte passes the input register, then the frame tracker, into the result register.
// Throughput: one byte per cycle while the input side is not stalled; the frame tracker updates all its state at once.
// A stalled status word holds in the output register while one more byte waits in the
// input register, so the input side stalls only when both are occupied.
// Reset (synchronous, active high) empties both registers and clears the frame state.
module serial_command_frame_checker
   import scfc_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff;

   logic       out_free;   // result register can take a word this cycle
   logic       advance;    // input word moves through the tracker
   logic       take;       // new word accepted
   status_type status;

   // The result register frees when it is empty or its word is being taken.
   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = in_valid_ff && out_free;

   // Accept while the input register is empty or draining this cycle.
   assign req_ready = !in_valid_ff || out_free;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the byte only on accept; hold it while stalled.
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Frame state advances exactly once per byte, as it moves to the result register.
   scfc_frame #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;

endmodule

// ----- src/scfc_checker.sv -----
`include "assert_macros.svh"

module scfc_checker
   import scfc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status
);

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "status word dropped or changed while stalled")

   `ASSERT_IMPLIES(a_ready_only_on_stall, !req_ready, rsp_valid && !rsp_ready, "input stalled while result side is free")

   `ASSERT_NEXT(a_no_double_valid, rsp_valid && rsp_ready && (rsp_status == ST_VALID), !(rsp_valid && rsp_ready && (rsp_status == ST_VALID)), "two valid commands in consecutive words")

   `ASSERT_NEXT(a_no_double_full, rsp_valid && rsp_ready && (rsp_status == ST_FULL), !(rsp_valid && rsp_ready && (rsp_status == ST_FULL)), "two frame-full words in a row")

endmodule

bind serial_command_frame_checker scfc_checker u_scfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status)
);

// ----- sim/tb_serial_command_frame_checker.sv -----
module tb_serial_command_frame_checker;
   import scfc_pkg::*;

   localparam int FRAME_LIMIT    = FRAME_BYTES_DEF;
   localparam int TOTAL_WORDS    = 950;
   localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
   localparam int DRAIN_CYCLES   = 10;    // settling time after the last status word is back
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int IDLE_PCT       = 37;

   // Ways a generated frame can be broken on purpose.
   typedef enum int {
      FL_NONE,
      FL_SUM,
      FL_LETTER,
      FL_ZERO,
      FL_NO_HASH,
      FL_BIG_VALUE,
      FL_NON_DIGIT,
      FL_SHORT,
      FL_OVERFLOW
   } frame_flaw_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;

   // Expected status words, oldest first.
   status_type expected_status_q[$];
   // Bytes of the next sequence to send.
   logic [7:0] pending_bytes[$];

   // Predicted frame tracker state.
   int         frame_len;
   bit         frame_hash;
   bit         frame_letter;
   bit         frame_has_zero;
   logic [7:0] frame_sum;
   logic [7:0] tail_bytes[3];   // newest in entry 0

   bit gaps_on;
   int hold_requests;
   int words_sent;
   int error_count;
   int idle_cycles;

   serial_command_frame_checker #(
      .FRAME_BYTES(FRAME_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Frame tracker prediction
   // ------------------------------------------------------------------

   function automatic void clear_frame();
      frame_len      = 0;
      frame_hash     = 1'b0;
      frame_letter   = 1'b0;
      frame_has_zero = 1'b0;
      frame_sum      = 8'd0;
   endfunction

   // Check the frame closed by '!': header, no zero byte, minimum length,
   // three digits worth at most 259 that match the body checksum.
   function automatic bit frame_passes();
      logic [7:0] d_hi;
      logic [7:0] d_mid;
      logic [7:0] d_lo;
      logic [7:0] body_sum;
      int         value;
      d_hi  = tail_bytes[2];
      d_mid = tail_bytes[1];
      d_lo  = tail_bytes[0];
      if (frame_len + 1 < 6 || !frame_hash || !frame_letter || frame_has_zero)
         return 1'b0;
      if (d_hi < CH_ZERO || d_hi > CH_NINE || d_mid < CH_ZERO || d_mid > CH_NINE ||
          d_lo < CH_ZERO || d_lo > CH_NINE)
         return 1'b0;
      value = (int'(d_hi) - int'(CH_ZERO)) * 100 + (int'(d_mid) - int'(CH_ZERO)) * 10
            + (int'(d_lo) - int'(CH_ZERO));
      if (value > 259)
         return 1'b0;
      // Sum covers letter through digits; take the digits back out.
      body_sum = frame_sum - d_hi - d_mid - d_lo;
      return value == int'(body_sum);
   endfunction

   function automatic status_type predict_status(input logic [7:0] rx);
      status_type st;
      // A full frame drops whatever comes next, even '#' or '!'.
      if (frame_len >= FRAME_LIMIT) begin
         clear_frame();
         return ST_FULL;
      end
      if (rx == CH_HASH)
         clear_frame();
      if (rx == CH_BANG) begin
         st = frame_passes() ? ST_VALID : ST_INVALID;
         clear_frame();
         return st;
      end
      if (frame_len == 0)
         frame_hash = (rx == CH_HASH);
      if (frame_len == 1)
         frame_letter = (rx == CH_A) || (rx == CH_P) || (rx == CH_L) || (rx == CH_R);
      if (rx == 8'h00)
         frame_has_zero = 1'b1;
      if (frame_len >= 1)
         frame_sum = frame_sum + rx;
      tail_bytes[2] = tail_bytes[1];
      tail_bytes[1] = tail_bytes[0];
      tail_bytes[0] = rx;
      frame_len++;
      return ST_STORED;
   endfunction

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // Offer one word; idle first at random, then hold valid until accepted.
   // Valid stays high after acceptance so back-to-back words need no toggle.
   task automatic send_byte(input logic [7:0] rx);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      expected_status_q.push_back(predict_status(rx));
      words_sent++;
   endtask

   task automatic send_pending();
      while (pending_bytes.size() != 0)
         send_byte(pending_bytes.pop_front());
   endtask

   // Drop valid and stop until every expected status word is back.
   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Frame builders
   // ------------------------------------------------------------------

   function automatic logic [7:0] random_body_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_HASH || c == CH_BANG);
      return c;
   endfunction

   function automatic logic [7:0] random_letter();
      case ($urandom_range(3))
         0: return CH_A;
         1: return CH_P;
         2: return CH_L;
         default: return CH_R;
      endcase
   endfunction

   function automatic int random_body_len();
      return ($urandom_range(9) == 0) ? $urandom_range(11, 58) : $urandom_range(0, 10);
   endfunction

   function automatic void add_digits(input int value);
      pending_bytes.push_back(CH_ZERO + 8'(value / 100));
      pending_bytes.push_back(CH_ZERO + 8'((value / 10) % 10));
      pending_bytes.push_back(CH_ZERO + 8'(value % 10));
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         pending_bytes.push_back(s[i]);
   endfunction

   // Queue one frame: '#', letter, body, three checksum digits, '!',
   // optionally broken in one chosen way.
   function automatic void build_frame(input logic [7:0] letter, input int body_len,
                                       input frame_flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] c;
      int         value;
      int         zero_pos;
      int         bad_pos;
      int         first_digit;
      if (flaw == FL_SHORT) begin
         pending_bytes.push_back(CH_HASH);
         pending_bytes.push_back(letter);
         repeat ($urandom_range(0, 2)) pending_bytes.push_back(random_body_byte());
         pending_bytes.push_back(CH_BANG);
         return;
      end
      if (flaw == FL_OVERFLOW)
         body_len = $urandom_range(59, 75);
      if (flaw == FL_ZERO && body_len == 0)
         body_len = 1;
      zero_pos = $urandom_range(0, (body_len > 0) ? body_len - 1 : 0);
      if (flaw != FL_NO_HASH)
         pending_bytes.push_back(CH_HASH);
      if (flaw == FL_LETTER) begin
         do c = random_body_byte();
         while (c == CH_A || c == CH_P || c == CH_L || c == CH_R);
         letter = c;
      end
      pending_bytes.push_back(letter);
      sum = letter;
      for (int i = 0; i < body_len; i++) begin
         c = (flaw == FL_ZERO && i == zero_pos) ? 8'h00 : random_body_byte();
         pending_bytes.push_back(c);
         sum = sum + c;
      end
      value = int'(sum);
      if (flaw == FL_SUM)
         value = (value + $urandom_range(1, 255)) % 256;
      if (flaw == FL_BIG_VALUE)
         value = $urandom_range(256, 259);
      first_digit = pending_bytes.size();
      add_digits(value);
      if (flaw == FL_NON_DIGIT) begin
         bad_pos = first_digit + $urandom_range(0, 2);
         do c = random_body_byte(); while (c >= CH_ZERO && c <= CH_NINE);
         pending_bytes[bad_pos] = c;
      end
      pending_bytes.push_back(CH_BANG);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Well-formed frames: shortest legal frame, a restart by '#',
   // a body byte at the top of the range.
   task automatic test_valid_frames();
      add_text("#A065!");
      add_text("#P#R082!");
      pending_bytes.push_back(CH_HASH);
      pending_bytes.push_back(CH_A);
      pending_bytes.push_back(8'hFF);
      add_text("064!");
      send_pending();
      wait_results_drained();
   endtask

   // Frames that must be rejected, one reason each.
   task automatic test_rejected_frames();
      pending_bytes.push_back(CH_HASH);       // zero byte in the body
      pending_bytes.push_back(CH_L);
      pending_bytes.push_back(8'h00);
      add_text("076!");
      add_text("#A!");                        // too short
      add_text("#A259!");                     // digits above 255
      add_text("AA065!");                     // not started by '#'
      add_text("#B066!");                     // bad command letter
      add_text("#A06:!");                     // non-digit in the checksum
      send_pending();
      wait_results_drained();
   endtask

   // Longest legal frame, then overflow with '!' and '#' as the dropped word.
   task automatic test_frame_full();
      build_frame(random_letter(), 58, FL_NONE);
      pending_bytes.push_back(CH_HASH);
      repeat (FRAME_LIMIT - 1) pending_bytes.push_back(random_body_byte());
      pending_bytes.push_back(CH_BANG);
      pending_bytes.push_back(CH_A);
      repeat (FRAME_LIMIT - 1) pending_bytes.push_back(random_body_byte());
      pending_bytes.push_back(CH_HASH);
      add_text("#A065!");
      send_pending();
      wait_results_drained();
   endtask

   // Stall the result side for a long stretch while frames keep coming,
   // so the block fills up and holds off its input.
   task automatic test_backpressure();
      hold_requests++;
      repeat (4) build_frame(random_letter(), random_body_len(), FL_NONE);
      send_pending();
      wait_results_drained();
   endtask

   task automatic test_random_traffic(input int stop_at, input bit with_gaps);
      int pick;
      gaps_on = with_gaps;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60)
            build_frame(random_letter(), random_body_len(), FL_NONE);
         else if (pick < 90)
            build_frame(random_letter(), random_body_len(),
                        frame_flaw_type'($urandom_range(FL_SUM, FL_OVERFLOW)));
         else
            repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(0, 255)));
         send_pending();
      end
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // Ready changes at the falling edge; a pending hold-off request wins.
   initial begin : result_receiver
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (gaps_on) begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each accepted status word with the oldest expectation.
   always @(posedge clock) begin : status_check
      status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: unexpected status word, expected none, actual %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_status !== want) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want, rsp_status);
               error_count++;
            end
         end
      end
   end

   // End the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      gaps_on       = 1'b1;
      hold_requests = 0;
      words_sent    = 0;
      clear_frame();
      for (int i = 0; i < 3; i++)
         tail_bytes[i] = 8'h00;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_valid_frames();
      test_rejected_frames();
      test_frame_full();
      test_backpressure();
      test_random_traffic(550, 1'b1);
      test_random_traffic(700, 1'b0);   // long stretch with no idling
      test_random_traffic(TOTAL_WORDS, 1'b1);

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_status_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/scfc_pkg.sv
src/scfc_frame.sv
src/serial_command_frame_checker.sv
src/scfc_checker.sv
sim/tb_serial_command_frame_checker.sv
